/* rtl/word_edit_neighbor_classifier_assert.svh */
// ----------------------------------------------------------------------------
// word_edit_neighbor_classifier_assert.svh
// assertion macros shared by the word edit neighbour classifier
// ----------------------------------------------------------------------------
`ifndef WORD_EDIT_NEIGHBOR_CLASSIFIER_ASSERT_SVH
`define WORD_EDIT_NEIGHBOR_CLASSIFIER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define WENC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// expression must never be true
`define WENC_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");

`endif

/* rtl/wenc_pkg.sv */
// ----------------------------------------------------------------------------
// wenc_pkg
// types, edit kind codes and helpers for the word edit neighbour classifier
// ----------------------------------------------------------------------------
`default_nettype none

package wenc_pkg;

   localparam int CHAR_W = 8;
   localparam int WORD_W = 128;
   localparam int LEN_W  = 5;
   localparam int KIND_W = 3;

   localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SWAP   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CHANGE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DELETE = 3'd4;

   // the two words of one request travelling down the chain
   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [LEN_W-1:0]  len_a;
      logic [LEN_W-1:0]  len_b;
      logic [LEN_W-1:0]  min_len;
   } word_type;

   // running comparison state handed from cell to cell
   typedef struct packed {
      logic [1:0]        ndiff;       // saturates at three
      logic [LEN_W-1:0]  first_pos;
      logic [CHAR_W-1:0] letter;
      logic              cross_first;
      logic              adj;
      logic              prev_mism;
      logic              same_found;
      logic [LEN_W-1:0]  same_pos;
      logic              indel_bad;
   } scan_type;

   // character at idx, zero past the sixteenth
   function automatic logic [CHAR_W-1:0] char_at(input logic [WORD_W-1:0] word,
                                                 input logic [LEN_W-1:0] idx);
      logic [CHAR_W-1:0] c;
      if (idx[LEN_W-1]) begin
         c = '0;
      end else begin
         c = word[{idx[LEN_W-2:0], 3'b000} +: CHAR_W];
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/wenc_cell.sv */
// ----------------------------------------------------------------------------
// wenc_cell
// one character position of the comparison chain, one register stage
// ----------------------------------------------------------------------------
`default_nettype none

module wenc_cell #(
   parameter int POS = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wenc_pkg::word_type     in_word,
   input  wenc_pkg::scan_type     in_scan,
   output logic                   in_ready,
   output logic                   out_valid,
   output wenc_pkg::word_type     out_word,
   output wenc_pkg::scan_type     out_scan,
   input  wire logic              out_ready
);

   localparam logic [wenc_pkg::LEN_W-1:0] POS_HERE = wenc_pkg::LEN_W'(POS);
   localparam logic [wenc_pkg::LEN_W-1:0] POS_NEXT = wenc_pkg::LEN_W'(POS + 1);

   logic                        valid_ff;
   wenc_pkg::word_type          word_ff;
   wenc_pkg::scan_type          scan_ff;
   wenc_pkg::scan_type          scan_in;

   logic [wenc_pkg::CHAR_W-1:0] a_k, b_k, a_n, b_n;
   logic                        act, mism, shift_ok;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      a_k = wenc_pkg::char_at(in_word.a, POS_HERE);
      b_k = wenc_pkg::char_at(in_word.b, POS_HERE);
      a_n = wenc_pkg::char_at(in_word.a, POS_NEXT);
      b_n = wenc_pkg::char_at(in_word.b, POS_NEXT);
      act = POS_HERE < in_word.min_len;
      mism = act && (a_k != b_k);
      // shorter word here against the longer one a place further on
      shift_ok = (in_word.len_a < in_word.len_b) ? (a_k == b_n) : (b_k == a_n);

      scan_in = in_scan;
      if (mism) begin
         scan_in.ndiff = (in_scan.ndiff == 2'd3) ? 2'd3 : in_scan.ndiff + 2'd1;
         if (in_scan.ndiff == 2'd0) begin
            scan_in.first_pos   = POS_HERE;
            scan_in.letter      = b_k;
            scan_in.cross_first = (a_k == b_n) && (a_n == b_k);
         end
         if (in_scan.ndiff == 2'd1) begin
            scan_in.adj = in_scan.prev_mism;
         end
      end
      // no mismatch in the common part: letter after it for an insertion
      if ((in_scan.ndiff == 2'd0) && (POS_HERE == in_word.min_len)) begin
         scan_in.letter = b_k;
      end
      scan_in.prev_mism = mism;
      if (act && (POS_NEXT < in_word.min_len) && !in_scan.same_found && (a_k == a_n)) begin
         scan_in.same_found = 1'b1;
         scan_in.same_pos   = POS_HERE;
      end
      if (act && (mism || (in_scan.ndiff != 2'd0)) && !shift_ok) begin
         scan_in.indel_bad = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= in_word;
         scan_ff <= scan_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
   assign out_scan  = scan_ff;

endmodule

`default_nettype wire

/* rtl/wenc_result.sv */
// ----------------------------------------------------------------------------
// wenc_result
// turns the finished scan into flags and an edit description, output register
// ----------------------------------------------------------------------------
`default_nettype none

module wenc_result (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 in_valid,
   input  wenc_pkg::word_type                        in_word,
   input  wenc_pkg::scan_type                        in_scan,
   output logic                                      in_ready,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_change_ok,
   output logic                                      rsp_indel_ok,
   output logic                                      rsp_swap_ok,
   output logic [wenc_pkg::KIND_W-1:0]               rsp_edit_kind,
   output logic [wenc_pkg::LEN_W-1:0]                rsp_edit_pos,
   output logic [wenc_pkg::CHAR_W-1:0]               rsp_edit_letter
);

   logic                          valid_ff;
   logic                          change_ok_ff, indel_ok_ff, swap_ok_ff;
   logic [wenc_pkg::KIND_W-1:0]   kind_ff;
   logic [wenc_pkg::LEN_W-1:0]    pos_ff;
   logic [wenc_pkg::CHAR_W-1:0]   letter_ff;

   logic                          change_ok_in, indel_ok_in, swap_ok_in;
   logic [wenc_pkg::KIND_W-1:0]   kind_in;
   logic [wenc_pkg::LEN_W-1:0]    pos_in;
   logic [wenc_pkg::CHAR_W-1:0]   letter_in;
   logic                          same_len, b_longer, a_longer;
   logic                          swap_same, swap_diff;

   assign in_ready = !valid_ff || !rsp_stall;

   always_comb begin
      same_len  = in_word.len_a == in_word.len_b;
      b_longer  = ({1'b0, in_word.len_a} + 6'd1) == {1'b0, in_word.len_b};
      a_longer  = ({1'b0, in_word.len_b} + 6'd1) == {1'b0, in_word.len_a};
      // identical words: a swap of two equal neighbours
      swap_same = (in_scan.ndiff == 2'd0) && in_scan.same_found;
      // two adjacent differences that cross over
      swap_diff = (in_scan.ndiff == 2'd2) && in_scan.adj && in_scan.cross_first;

      change_ok_in = same_len && (in_scan.ndiff == 2'd1);
      swap_ok_in   = same_len && swap_diff;
      indel_ok_in  = (a_longer || b_longer) && !in_scan.indel_bad;

      kind_in   = wenc_pkg::KIND_NONE;
      pos_in    = '0;
      letter_in = '0;
      if (same_len) begin
         if (swap_same) begin
            kind_in = wenc_pkg::KIND_SWAP;
            pos_in  = in_scan.same_pos;
         end else if (swap_diff) begin
            kind_in = wenc_pkg::KIND_SWAP;
            pos_in  = in_scan.first_pos;
         end else if (in_scan.ndiff != 2'd0) begin
            kind_in   = wenc_pkg::KIND_CHANGE;
            pos_in    = in_scan.first_pos;
            letter_in = in_scan.letter;
         end
      end else if (b_longer) begin
         kind_in   = wenc_pkg::KIND_INSERT;
         pos_in    = in_scan.first_pos;
         letter_in = in_scan.letter;
      end else if (a_longer) begin
         kind_in = wenc_pkg::KIND_DELETE;
         pos_in  = in_scan.first_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         change_ok_ff <= change_ok_in;
         indel_ok_ff  <= indel_ok_in;
         swap_ok_ff   <= swap_ok_in;
         kind_ff      <= kind_in;
         pos_ff       <= pos_in;
         letter_ff    <= letter_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_change_ok   = change_ok_ff;
   assign rsp_indel_ok    = indel_ok_ff;
   assign rsp_swap_ok     = swap_ok_ff;
   assign rsp_edit_kind   = kind_ff;
   assign rsp_edit_pos    = pos_ff;
   assign rsp_edit_letter = letter_ff;

endmodule

`default_nettype wire

/* rtl/word_edit_neighbor_classifier.sv */
// ----------------------------------------------------------------------------
// word_edit_neighbor_classifier
// classifies two words as one change, one insertion or deletion, or one swap
// ----------------------------------------------------------------------------
// A new request is taken every cycle while req_stall is low. The words
// pass down a chain of MAX_LEN registered cells, one per character position,
// each folding its position into the running comparison; a final register
// turns that into the flags and the edit description. Each stage holds
// while the one after it is full and stalled, so bubbles close up and a
// request can still be taken while a finished response waits. Lengths
// above MAX_LEN count as MAX_LEN.
// ----------------------------------------------------------------------------
`default_nettype none

`include "word_edit_neighbor_classifier_assert.svh"

module word_edit_neighbor_classifier #(
   parameter int MAX_LEN = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [63:0]                   req_word_a_low,
   input  wire logic [63:0]                   req_word_a_high,
   input  wire logic [4:0]                    req_word_a_len,
   input  wire logic [63:0]                   req_word_b_low,
   input  wire logic [63:0]                   req_word_b_high,
   input  wire logic [4:0]                    req_word_b_len,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_change_ok,
   output logic                               rsp_indel_ok,
   output logic                               rsp_swap_ok,
   output logic [2:0]                         rsp_edit_kind,
   output logic [4:0]                         rsp_edit_pos,
   output logic [7:0]                         rsp_edit_letter
);

   localparam logic [wenc_pkg::LEN_W-1:0] LEN_CAP = wenc_pkg::LEN_W'(MAX_LEN);

   logic                          link_valid [MAX_LEN+1];
   logic                          link_ready [MAX_LEN+1];
   wenc_pkg::word_type            link_word  [MAX_LEN+1];
   wenc_pkg::scan_type            link_scan  [MAX_LEN+1];

   logic [wenc_pkg::LEN_W-1:0]    len_a, len_b, min_len;

   always_comb begin
      len_a   = (req_word_a_len > LEN_CAP) ? LEN_CAP : req_word_a_len;
      len_b   = (req_word_b_len > LEN_CAP) ? LEN_CAP : req_word_b_len;
      min_len = (len_a < len_b) ? len_a : len_b;

      link_valid[0]        = req_valid;
      link_word[0].a       = {req_word_a_high, req_word_a_low};
      link_word[0].b       = {req_word_b_high, req_word_b_low};
      link_word[0].len_a   = len_a;
      link_word[0].len_b   = len_b;
      link_word[0].min_len = min_len;

      link_scan[0]           = '0;
      // no mismatch found yet means the end of the shorter word
      link_scan[0].first_pos = min_len;
   end

   assign req_stall = !link_ready[0];

   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      wenc_cell #(
         .POS (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_word   (link_word[i]),
         .in_scan   (link_scan[i]),
         .in_ready  (link_ready[i]),
         .out_valid (link_valid[i+1]),
         .out_word  (link_word[i+1]),
         .out_scan  (link_scan[i+1]),
         .out_ready (link_ready[i+1])
      );
   end

   wenc_result u_result (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (link_valid[MAX_LEN]),
      .in_word         (link_word[MAX_LEN]),
      .in_scan         (link_scan[MAX_LEN]),
      .in_ready        (link_ready[MAX_LEN]),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_change_ok   (rsp_change_ok),
      .rsp_indel_ok    (rsp_indel_ok),
      .rsp_swap_ok     (rsp_swap_ok),
      .rsp_edit_kind   (rsp_edit_kind),
      .rsp_edit_pos    (rsp_edit_pos),
      .rsp_edit_letter (rsp_edit_letter)
   );

   // a request is only held off when the whole chain backs up behind the output
   `WENC_ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, req_stall, rsp_valid && rsp_stall)
   // one change and one swap or indel cannot both describe the same pair
   `WENC_ASSERT_NEVER(a_flags_exclusive, clock, reset, rsp_valid && rsp_change_ok && (rsp_swap_ok || rsp_indel_ok))
   // a swap flag always comes with a swap description
   `WENC_ASSERT_IMPLIES(a_swap_described, clock, reset, rsp_valid && rsp_swap_ok, rsp_edit_kind == wenc_pkg::KIND_SWAP)
   // nothing to describe leaves position and letter clear
   `WENC_ASSERT_IMPLIES(a_none_is_clear, clock, reset, rsp_valid && (rsp_edit_kind == wenc_pkg::KIND_NONE), (rsp_edit_pos == 5'd0) && (rsp_edit_letter == 8'd0))

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the word edit neighbour classifier
// ----------------------------------------------------------------------------
// Word pairs go in through the request channel. Each accepted pair is run
// through an in-bench model of the one-edit classification and queued. Every
// response taken from the block is checked field by field against the oldest
// queued prediction. A directed set covers empty and full words, saturated
// lengths, ignored tails and each edit kind. The random part mostly builds
// near neighbours (changes, swaps, insertions, deletions) over small
// alphabets, with some fully random pairs. Both sides idle in random bursts.
// The receiver holds off once for a long stretch so the pipeline fills. The
// sender pauses twice until the pipeline drains.
// ----------------------------------------------------------------------------
module testbench;

   localparam int MAX_LEN     = 16;
   localparam int ITEM_COUNT  = 1150;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_AT    = 700;
   localparam int QUIET_FROM  = 1000;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [63:0] a_low;
      logic [63:0] a_high;
      logic [4:0]  a_len;
      logic [63:0] b_low;
      logic [63:0] b_high;
      logic [4:0]  b_len;
   } word_pair_type;

   typedef struct packed {
      logic        change_ok;
      logic        indel_ok;
      logic        swap_ok;
      logic [2:0]  edit_kind;
      logic [4:0]  edit_pos;
      logic [7:0]  edit_letter;
   } edit_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_word_a_low = '0;
   logic [63:0] req_word_a_high = '0;
   logic [4:0]  req_word_a_len = '0;
   logic [63:0] req_word_b_low = '0;
   logic [63:0] req_word_b_high = '0;
   logic [4:0]  req_word_b_len = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_change_ok;
   logic        rsp_indel_ok;
   logic        rsp_swap_ok;
   logic [2:0]  rsp_edit_kind;
   logic [4:0]  rsp_edit_pos;
   logic [7:0]  rsp_edit_letter;

   word_edit_neighbor_classifier #(.MAX_LEN(MAX_LEN)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_word_a_low  (req_word_a_low),
      .req_word_a_high (req_word_a_high),
      .req_word_a_len  (req_word_a_len),
      .req_word_b_low  (req_word_b_low),
      .req_word_b_high (req_word_b_high),
      .req_word_b_len  (req_word_b_len),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_change_ok   (rsp_change_ok),
      .rsp_indel_ok    (rsp_indel_ok),
      .rsp_swap_ok     (rsp_swap_ok),
      .rsp_edit_kind   (rsp_edit_kind),
      .rsp_edit_pos    (rsp_edit_pos),
      .rsp_edit_letter (rsp_edit_letter)
   );

   always #6 clock = ~clock;

   function automatic edit_result_type classify_edit(word_pair_type r);
      logic [7:0]      ca [16];
      logic [7:0]      cb [16];
      logic [7:0]      sh [16];
      logic [7:0]      lg [16];
      logic [7:0]      c;
      int              la, lb, ns, ndiff, first_diff, i, j, k;
      bit              skipped, hit, fits;
      edit_result_type e;
      e = '0;
      for (k = 0; k < 16; k++) begin
         ca[k] = (k < 8) ? r.a_low[8*k +: 8] : r.a_high[8*(k-8) +: 8];
         cb[k] = (k < 8) ? r.b_low[8*k +: 8] : r.b_high[8*(k-8) +: 8];
      end
      la = (r.a_len > MAX_LEN) ? MAX_LEN : int'(r.a_len);
      lb = (r.b_len > MAX_LEN) ? MAX_LEN : int'(r.b_len);
      if (la == lb) begin
         ndiff = 0;
         first_diff = 0;
         for (k = 0; k < la; k++) begin
            if (ca[k] != cb[k]) begin
               if (ndiff == 0) first_diff = k;
               ndiff++;
            end
         end
         e.change_ok = (ndiff == 1);
         hit = 1'b0;
         for (k = 0; k + 1 < la && !hit; k++) begin
            fits = 1'b1;
            for (j = 0; j < la; j++) begin
               c = (j == k) ? ca[k+1] : (j == k + 1) ? ca[k] : ca[j];
               if (c != cb[j]) fits = 1'b0;
            end
            if (fits) begin
               hit = 1'b1;
               e.edit_pos = 5'(k);
            end
         end
         e.swap_ok = hit && (ndiff != 0);
         if (hit) begin
            e.edit_kind = wenc_pkg::KIND_SWAP;
         end else if (ndiff != 0) begin
            e.edit_kind   = wenc_pkg::KIND_CHANGE;
            e.edit_pos    = 5'(first_diff);
            e.edit_letter = cb[first_diff];
         end
      end else if (la + 1 == lb || lb + 1 == la) begin
         ns = (la < lb) ? la : lb;
         for (k = 0; k < 16; k++) begin
            sh[k] = (la < lb) ? ca[k] : cb[k];
            lg[k] = (la < lb) ? cb[k] : ca[k];
         end
         i = 0;
         j = 0;
         skipped = 1'b0;
         e.indel_ok = 1'b1;
         // walk both words, allowing one skip in the longer
         while (e.indel_ok && i < ns && j < ns + 1) begin
            if (sh[i] == lg[j]) begin
               i++;
               j++;
            end else if (!skipped) begin
               skipped = 1'b1;
               j++;
            end else begin
               e.indel_ok = 1'b0;
            end
         end
         i = 0;
         if (la + 1 == lb) begin
            while (i < la && ca[i] == cb[i]) i++;
            e.edit_kind   = wenc_pkg::KIND_INSERT;
            e.edit_pos    = 5'(i);
            e.edit_letter = cb[i];
         end else begin
            while (i < lb && ca[i] == cb[i]) i++;
            e.edit_kind = wenc_pkg::KIND_DELETE;
            e.edit_pos  = 5'(i);
         end
      end
      return e;
   endfunction

   class edit_scoreboard;
      edit_result_type expected_edits[$];
      int              mismatch_count = 0;

      function int pending();
         return expected_edits.size();
      endfunction

      function void note_request(word_pair_type r);
         expected_edits.push_back(classify_edit(r));
      endfunction

      function void check_response(edit_result_type got);
         edit_result_type want;
         if (expected_edits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("response with no request outstanding: kind %0d pos %0d letter %02h",
                        got.edit_kind, got.edit_pos, got.edit_letter);
            return;
         end
         want = expected_edits.pop_front();
         if (got.change_ok !== want.change_ok || got.indel_ok !== want.indel_ok ||
             got.swap_ok !== want.swap_ok || got.edit_kind !== want.edit_kind ||
             got.edit_pos !== want.edit_pos || got.edit_letter !== want.edit_letter) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("mismatch: expected change %0b indel %0b swap %0b kind %0d pos %0d letter %02h",
                        want.change_ok, want.indel_ok, want.swap_ok, want.edit_kind,
                        want.edit_pos, want.edit_letter);
               $display("          got      change %0b indel %0b swap %0b kind %0d pos %0d letter %02h",
                        got.change_ok, got.indel_ok, got.swap_ok, got.edit_kind,
                        got.edit_pos, got.edit_letter);
            end
         end
      endfunction
   endclass

   edit_scoreboard sb = new();

   // receiver side: checks and stall pattern
   edit_result_type got_edit;
   int              stall_left = 0;
   int              hold_left = 0;
   logic            hold_off_req = 1'b0;
   bit              hold_off_done = 1'b0;
   logic            quiet_phase = 1'b0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_edit.change_ok   = rsp_change_ok;
         got_edit.indel_ok    = rsp_indel_ok;
         got_edit.swap_ok     = rsp_swap_ok;
         got_edit.edit_kind   = rsp_edit_kind;
         got_edit.edit_pos    = rsp_edit_pos;
         got_edit.edit_letter = rsp_edit_letter;
         sb.check_response(got_edit);
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_off_req && !hold_off_done) begin
         // long hold-off so the pipeline fills and back-pressures requests
         hold_off_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (quiet_phase) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("word_edit_neighbor_classifier test failed");
         $finish;
      end
   end

   function automatic logic [127:0] pack_text(string s);
      logic [127:0] w;
      int           k;
      w = '0;
      for (k = 0; k < s.len() && k < 16; k++) w[8*k +: 8] = s[k];
      return w;
   endfunction

   function automatic logic [7:0] random_char(int alpha);
      if (alpha >= 256) return 8'($urandom_range(0, 255));
      return 8'h61 + 8'($urandom_range(0, alpha - 1));   // lower-case letters
   endfunction

   task automatic idle_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // present one request and wait until it is taken
   task automatic offer(word_pair_type r, bit may_idle);
      req_valid       <= 1'b1;
      req_word_a_low  <= r.a_low;
      req_word_a_high <= r.a_high;
      req_word_a_len  <= r.a_len;
      req_word_b_low  <= r.b_low;
      req_word_b_high <= r.b_high;
      req_word_b_len  <= r.b_len;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      if (may_idle && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 18));
   endtask

   task automatic offer_words(logic [127:0] a, int la, logic [127:0] b, int lb);
      word_pair_type r;
      r.a_low  = a[63:0];
      r.a_high = a[127:64];
      r.a_len  = 5'(la);
      r.b_low  = b[63:0];
      r.b_high = b[127:64];
      r.b_len  = 5'(lb);
      offer(r, 1'b1);
   endtask

   task automatic offer_text(string a, string b);
      offer_words(pack_text(a), a.len(), pack_text(b), b.len());
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // mostly near neighbours over a small alphabet, some pure noise
   task automatic make_pair(output word_pair_type r);
      logic [7:0]   wa [16];
      logic [7:0]   wb [16];
      logic [127:0] pa, pb;
      int           la, lb, alpha, p, q, k;
      alpha = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 6);
      la = $urandom_range(0, MAX_LEN);
      for (k = 0; k < 16; k++)
         wa[k] = (k < la) ? random_char(alpha) : 8'($urandom_range(0, 255));
      wb = wa;
      lb = la;
      p = (la > 0) ? $urandom_range(0, la - 1) : 0;
      q = (la > 1) ? $urandom_range(0, la - 2) : 0;
      case ($urandom_range(0, 9))
         0: ;
         1: if (la > 0) wb[p] = random_char(alpha);
         2: if (la > 1) begin
            wb[q] = wa[q+1];
            wb[q+1] = wa[q];
         end
         3: if (la < MAX_LEN) begin
            q = $urandom_range(0, la);
            for (k = 15; k > q; k--) wb[k] = wa[k-1];
            wb[q] = random_char(alpha);
            lb = la + 1;
         end
         4: if (la > 0) begin
            for (k = p; k < 15; k++) wb[k] = wa[k+1];
            lb = la - 1;
         end
         5: if (la > 0) begin
            wb[p] = random_char(alpha);
            wb[$urandom_range(0, la - 1)] = random_char(alpha);
         end
         6: if (la > 1) begin
            wb[q] = wa[q+1];
            wb[q+1] = wa[q];
            wb[$urandom_range(0, la - 1)] = random_char(alpha);
         end
         7: begin
            lb = la + $urandom_range(0, 2) - 1;
            if (lb < 0) lb = 0;
            if (lb > MAX_LEN) lb = MAX_LEN;
            for (k = 0; k < lb; k++) wb[k] = random_char(alpha);
         end
         8: lb = $urandom_range(0, MAX_LEN);
         default: begin
            lb = $urandom_range(0, MAX_LEN);
            for (k = 0; k < 16; k++) begin
               wa[k] = 8'($urandom_range(0, 255));
               wb[k] = 8'($urandom_range(0, 255));
            end
         end
      endcase
      // junk past the end of the second word
      if ($urandom_range(0, 1) == 0)
         for (k = lb; k < 16; k++) wb[k] = 8'($urandom_range(0, 255));
      for (k = 0; k < 16; k++) begin
         pa[8*k +: 8] = wa[k];
         pb[8*k +: 8] = wb[k];
      end
      r.a_low  = pa[63:0];
      r.a_high = pa[127:64];
      r.b_low  = pb[63:0];
      r.b_high = pb[127:64];
      r.a_len  = 5'(la);
      r.b_len  = 5'(lb);
      // full-length words sometimes carry an over-range length
      if (la == MAX_LEN && $urandom_range(0, 3) == 0) r.a_len = 5'($urandom_range(MAX_LEN, 31));
      if (lb == MAX_LEN && $urandom_range(0, 3) == 0) r.b_len = 5'($urandom_range(MAX_LEN, 31));
   endtask

   initial begin
      word_pair_type r;
      int            n;
      bit            may_idle;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer_words('0, 0, '0, 0);
      offer_words('1, 16, '1, 16);
      offer_words('1, 16, ~(128'h1 << 120), 16);
      offer_words('0, 16, 128'h80, 16);
      offer_words(pack_text("abcdefghijklmnop"), 31, pack_text("abcdefghijklmnop"), 16);
      offer_words(pack_text("abcdefghijklmnop"), 20, pack_text("abcdefghijklmno"), 15);
      offer_text("abc", "abc");
      offer_text("aab", "aab");
      offer_text("abcd", "abed");
      offer_text("abcd", "abdc");
      offer_text("ab", "ba");
      offer_text("abc", "abxc");
      offer_text("abc", "xabc");
      offer_text("abc", "abcx");
      offer_text("abcd", "abd");
      offer_text("abcd", "bcd");
      offer_text("abc", "abcde");
      offer_text("abcd", "xbcy");
      offer_text("abc", "xbcd");
      offer_words(pack_text("ab") | (128'hdead_beef << 16), 2,
                  pack_text("ab") | (128'h1234_5678 << 40), 2);
      offer_text("a", "b");
      offer_text("abcdefghijklmno", "abcdefghijklmnoz");
      offer_text("", "q");
      offer_text("q", "");
      wait_for_drain();

      for (n = 0; n < ITEM_COUNT; n++) begin
         if (n == HOLD_AT) hold_off_req <= 1'b1;
         if (n == QUIET_FROM) quiet_phase <= 1'b1;
         if (n == DRAIN_AT) wait_for_drain();
         // keep offering while the receiver holds off, and at the end
         may_idle = (n < HOLD_AT || n >= HOLD_AT + 120) && n < QUIET_FROM;
         make_pair(r);
         offer(r, may_idle);
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (MAX_LEN + 8) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.pending() == 0)
         $display("word_edit_neighbor_classifier test passed");
      else
         $display("word_edit_neighbor_classifier test failed");
      $finish;
   end

endmodule
